[hw/rtl/fsat_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package fsat_pkg;

    localparam int TAPS       = 64;
    localparam int CNT_W      = $clog2(TAPS);
    localparam int COEF_IDX_W = 6;
    localparam int SMP_W      = 16;
    localparam int PROD_W     = 2 * SMP_W;
    localparam int ACC_W      = PROD_W + $clog2(TAPS);
    localparam int FRAC       = 15;
    localparam int Q_W        = ACC_W - FRAC;
    localparam int S_DATA_W   = ((COEF_IDX_W + 2 * SMP_W + 7) / 8) * 8;
    localparam int M_DATA_W   = ((SMP_W + 7) / 8) * 8;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_FILTER = 1'b1;

    localparam logic signed [SMP_W-1:0] SAT_MAX = {1'b0, {(SMP_W-1){1'b1}}};
    localparam logic signed [SMP_W-1:0] SAT_MIN = {1'b1, {(SMP_W-1){1'b0}}};

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic smp_en;
        logic coef_rot;
        logic coef_we;
    } t_cell_ctrl;

endpackage
`default_nettype wire

[hw/rtl/fsat_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
module fsat_cell (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire fsat_pkg::t_cell_ctrl            i_ctrl,
    input  wire logic signed [fsat_pkg::SMP_W-1:0] i_smp_prev,
    input  wire logic signed [fsat_pkg::SMP_W-1:0] i_coef_prev,
    input  wire logic signed [fsat_pkg::SMP_W-1:0] i_coef_wdata,
    output logic signed [fsat_pkg::SMP_W-1:0]    o_smp,
    output logic signed [fsat_pkg::SMP_W-1:0]    o_coef
);
    import fsat_pkg::*;

    logic signed [SMP_W-1:0] r_smp;
    logic signed [SMP_W-1:0] r_coef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smp  <= '0;
            r_coef <= '0;
        end else begin
            if (i_ctrl.smp_en) begin
                r_smp <= i_smp_prev;
            end
            if (i_ctrl.coef_rot) begin
                r_coef <= i_coef_prev;
            end else if (i_ctrl.coef_we) begin
                r_coef <= i_coef_wdata;
            end
        end
    end

    assign o_smp  = r_smp;
    assign o_coef = r_coef;

endmodule
`default_nettype wire

[hw/rtl/fsat_mac.sv]
`timescale 1ns / 1ps
`default_nettype none
module fsat_mac (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_clr,
    input  wire                                  i_vld,
    input  wire logic signed [fsat_pkg::SMP_W-1:0] i_coef,
    input  wire logic signed [fsat_pkg::SMP_W-1:0] i_smp,
    output logic signed [fsat_pkg::SMP_W-1:0]    o_result
);
    import fsat_pkg::*;

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_prod_vld;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [Q_W-1:0]    q;
    logic [Q_W-SMP_W:0]       hi;
    logic                     in_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_coef * i_smp;
        if (i_clr) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
        end
    end

    // floor shift, then clamp to Q1.15
    always_comb begin
        q        = r_acc[ACC_W-1:FRAC];
        hi       = q[Q_W-1:SMP_W-1];
        in_range = (&hi) || !(|hi);
        if (in_range) begin
            o_result = q[SMP_W-1:0];
        end else if (q[Q_W-1]) begin
            o_result = SAT_MIN;
        end else begin
            o_result = SAT_MAX;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/fir_filter_saturating.sv]
`timescale 1ns / 1ps
// A sample word's result is registered on the output after the run, drain and done states.
// A new word is accepted only in idle, after the previous sample's tap walk by the single
// multiply-accumulate over the rotating chain of tap cells; later while the previous result
// still waits on the output. A coefficient load word is accepted in idle and keeps the block idle.
// Reset (synchronous, active low) clears coefficients, delay line, control and output valid.
`default_nettype none
module fir_filter_saturating (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_s_tvalid,
    output logic                                  o_s_tready,
    // [5:0] coef_index, [21:6] coef_value, [37:22] sample, rest zero
    input  wire [fsat_pkg::S_DATA_W-1:0]          i_s_tdata,
    // [0] func
    input  wire                                   i_s_tuser,
    output logic                                  o_m_tvalid,
    input  wire                                   i_m_tready,
    // [15:0] filtered
    output logic [fsat_pkg::M_DATA_W-1:0]         o_m_tdata
);
    import fsat_pkg::*;

    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic                    r_out_vld, n_out_vld;
    logic signed [SMP_W-1:0] r_out, n_out;

    logic                    s_fire, load_fire, smp_fire, run, out_load;
    logic [COEF_IDX_W-1:0]   coef_index;
    logic signed [SMP_W-1:0] coef_value, sample, chain_in, result;

    logic signed [SMP_W-1:0] smp_q  [TAPS];
    logic signed [SMP_W-1:0] coef_q [TAPS];

    assign coef_index = i_s_tdata[COEF_IDX_W-1:0];
    assign coef_value = i_s_tdata[COEF_IDX_W+SMP_W-1:COEF_IDX_W];
    assign sample     = i_s_tdata[COEF_IDX_W+2*SMP_W-1:COEF_IDX_W+SMP_W];

    assign o_s_tready = (r_state == S_IDLE);
    assign s_fire     = i_s_tvalid && o_s_tready;
    assign load_fire  = s_fire && (i_s_tuser == FUNC_LOAD);
    assign smp_fire   = s_fire && (i_s_tuser == FUNC_FILTER);
    assign run        = (r_state == S_RUN);
    assign chain_in   = run ? smp_q[TAPS-1] : sample;

    genvar k;
    generate
        for (k = 0; k < TAPS; k++) begin : g_tap
            t_cell_ctrl              ctrl;
            logic signed [SMP_W-1:0] smp_prev, coef_prev;

            assign ctrl.smp_en   = smp_fire || run;
            assign ctrl.coef_rot = run;
            assign ctrl.coef_we  = load_fire && (32'(coef_index) == 32'(k));

            if (k == 0) begin : g_head
                assign smp_prev  = chain_in;
                assign coef_prev = coef_q[TAPS-1];
            end else begin : g_body
                assign smp_prev  = smp_q[k-1];
                assign coef_prev = coef_q[k-1];
            end

            fsat_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (ctrl),
                .i_smp_prev   (smp_prev),
                .i_coef_prev  (coef_prev),
                .i_coef_wdata (coef_value),
                .o_smp        (smp_q[k]),
                .o_coef       (coef_q[k])
            );
        end
    endgenerate

    fsat_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clr    (smp_fire),
        .i_vld    (run),
        .i_coef   (coef_q[TAPS-1]),
        .i_smp    (smp_q[TAPS-1]),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_out     = r_out;
        n_out_vld = r_out_vld && !i_m_tready;
        out_load  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (smp_fire) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(TAPS - 1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_vld || i_m_tready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (out_load) begin
            n_out     = result;
            n_out_vld = 1'b1;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = M_DATA_W'($unsigned(r_out));

    a_sample_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        smp_fire |=> (r_state == S_RUN))
        else $error("sample word did not start the tap walk");

    a_load_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_fire |=> (r_state == S_IDLE))
        else $error("coefficient load left idle");

    a_walk_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (run && (r_cnt == CNT_W'(TAPS - 1))) |=> (r_state == S_DRAIN))
        else $error("tap walk did not end after all taps");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> ($past(r_state) == S_DONE))
        else $error("result word raised outside completion");

endmodule
`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
    import fsat_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RAND_WORDS  = 1600;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = TAPS + 3 + 40;

    typedef logic signed [SMP_W-1:0] t_q15;

    typedef struct {
        logic            func;
        logic [5:0]      idx;
        t_q15            coef;
        t_q15            smp;
        bit              typed;
        t_q15            want;
    } t_stim_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;

    fir_filter_saturating dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),   // [5:0] coef_index, [21:6] coef_value, [37:22] sample
        .i_s_tuser  (s_tuser),   // [0] func
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)    // [15:0] filtered
    );

    // predictor state
    t_q15       coef_store [TAPS];
    t_q15       delay_line [TAPS];
    logic [5:0] wr_ptr;
    t_q15       pending_filtered [$];

    int mismatches;
    int cycles;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_off;

    t_stim_row directed_rows [23];

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver: random back-pressure plus one long hold-off
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off = hold_off - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic report_mismatch(input string what, input t_q15 got, input t_q15 want);
        mismatches++;
        $display("mismatch at cycle %0d: %s got %0d want %0d", cycles, what, got, want);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_filtered.size() == 0) begin
                report_mismatch("unexpected word, filtered", t_q15'(m_tdata), '0);
            end else begin
                t_q15 want;
                want = pending_filtered.pop_front();
                if (t_q15'(m_tdata[SMP_W-1:0]) !== want)
                    report_mismatch("filtered", t_q15'(m_tdata[SMP_W-1:0]), want);
            end
        end
    end

    function automatic void load_coef(input logic [5:0] idx, input t_q15 value);
        if (int'(idx) < TAPS)
            coef_store[idx] = value;
    endfunction

    function automatic t_q15 filter_sample(input t_q15 x);
        logic signed [47:0] acc;
        logic signed [47:0] q;
        logic [5:0]         pos;
        delay_line[wr_ptr] = x;
        acc = '0;
        for (int k = 0; k < TAPS; k++) begin
            pos = wr_ptr - 6'(k);
            acc = acc + coef_store[k] * delay_line[pos];
        end
        q = acc >>> 15;
        wr_ptr = wr_ptr + 6'd1;
        if (q > 48'sd32767)
            return SAT_MAX;
        else if (q < -48'sd32768)
            return SAT_MIN;
        return t_q15'(q);
    endfunction

    task automatic send_word(input logic func, input logic [5:0] idx, input t_q15 coef,
                             input t_q15 smp);
        logic [S_DATA_W-1:0] d;
        d = '0;
        d[5:0]   = idx;
        d[21:6]  = coef;
        d[37:22] = smp;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= d;
        do @(posedge i_clk); while (!(s_tvalid && s_tready));
        @(negedge i_clk);
    endtask

    task automatic apply_word(input logic func, input logic [5:0] idx, input t_q15 coef,
                              input t_q15 smp, input bit typed, input t_q15 want);
        t_q15 got;
        send_word(func, idx, coef, smp);
        if (func == FUNC_LOAD) begin
            load_coef(idx, coef);
        end else begin
            got = filter_sample(smp);
            pending_filtered.push_back(typed ? want : got);
        end
    endtask

    task automatic random_words(input int count);
        logic       func;
        logic [5:0] idx;
        t_q15       coef;
        t_q15       smp;
        for (int n = 0; n < count; n++) begin
            func = ($urandom_range(3) == 0) ? FUNC_LOAD : FUNC_FILTER;
            idx  = 6'($urandom);
            case ($urandom_range(3))
                0: coef = t_q15'($urandom);
                1: coef = '0;
                default: coef = t_q15'($urandom_range(4095)) - t_q15'(2048);
            endcase
            case ($urandom_range(7))
                0: smp = SAT_MAX;
                1: smp = SAT_MIN;
                default: smp = t_q15'($urandom);
            endcase
            apply_word(func, idx, coef, smp, 1'b0, '0);
        end
    endtask

    initial begin
        directed_rows = '{
            // cleared store: outputs are zero whatever the sample
            '{FUNC_FILTER, 6'd0,  16'sd0,      16'sd32767,  1'b1, 16'sd0},
            '{FUNC_FILTER, 6'd63, -16'sd32768, -16'sd32768, 1'b1, 16'sd0},
            '{FUNC_LOAD,   6'd0,  16'sd32767,  16'sd1234,   1'b0, 16'sd0},
            '{FUNC_LOAD,   6'd63, -16'sd32768, -16'sd1,     1'b0, 16'sd0},
            '{FUNC_FILTER, 6'd5,  16'sd77,     16'sd0,      1'b0, 16'sd0},
            '{FUNC_LOAD,   6'd1,  16'sd32767,  16'sd0,      1'b0, 16'sd0},
            '{FUNC_LOAD,   6'd2,  16'sd32767,  16'sd0,      1'b0, 16'sd0},
            '{FUNC_LOAD,   6'd3,  16'sd32767,  16'sd0,      1'b0, 16'sd0},
            // four full-scale taps drive the sum past both rails
            '{FUNC_FILTER, 6'd0,  16'sd0,      16'sd32767,  1'b0, 16'sd0},
            '{FUNC_FILTER, 6'd0,  16'sd0,      16'sd32767,  1'b0, 16'sd0},
            '{FUNC_FILTER, 6'd0,  16'sd0,      16'sd32767,  1'b0, 16'sd0},
            '{FUNC_FILTER, 6'd0,  16'sd0,      16'sd32767,  1'b1, 16'sd32767},
            '{FUNC_FILTER, 6'd0,  16'sd0,      -16'sd32768, 1'b0, 16'sd0},
            '{FUNC_FILTER, 6'd0,  16'sd0,      -16'sd32768, 1'b0, 16'sd0},
            '{FUNC_FILTER, 6'd0,  16'sd0,      -16'sd32768, 1'b0, 16'sd0},
            '{FUNC_FILTER, 6'd0,  16'sd0,      -16'sd32768, 1'b1, -16'sd32768},
            '{FUNC_LOAD,   6'd0,  16'sd1,      16'sd32767,  1'b0, 16'sd0},
            '{FUNC_LOAD,   6'd1,  16'sd0,      16'sd0,      1'b0, 16'sd0},
            '{FUNC_LOAD,   6'd2,  16'sd0,      16'sd0,      1'b0, 16'sd0},
            '{FUNC_LOAD,   6'd3,  16'sd0,      16'sd0,      1'b0, 16'sd0},
            '{FUNC_LOAD,   6'd63, 16'sd0,      16'sd0,      1'b0, 16'sd0},
            // truncation rounds toward minus infinity
            '{FUNC_FILTER, 6'd63, -16'sd32768, -16'sd1,     1'b1, -16'sd1},
            '{FUNC_FILTER, 6'd42, 16'sd32767,  16'sd1,      1'b1, 16'sd0}
        };

        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        s_tvalid      = 1'b0;
        s_tuser       = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        mismatches    = 0;
        cycles        = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off      = 0;
        wr_ptr        = '0;
        for (int k = 0; k < TAPS; k++) begin
            coef_store[k] = '0;
            delay_line[k] = '0;
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[r])
            apply_word(directed_rows[r].func, directed_rows[r].idx, directed_rows[r].coef,
                       directed_rows[r].smp, directed_rows[r].typed, directed_rows[r].want);

        send_idle_pct = 16;
        recv_idle_pct = 88;
        random_words(RAND_WORDS / 3);

        send_idle_pct = 88;
        recv_idle_pct = 16;
        random_words(RAND_WORDS / 3);

        // long receiver hold-off while words keep coming
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off      = HOLD_CYCLES;
        random_words(RAND_WORDS - 2 * (RAND_WORDS / 3));

        s_tvalid <= 1'b0;
        while (pending_filtered.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatches == 0 && pending_filtered.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
